### sv/tvrs_pkg.sv
// Shared types and constants of the torque vector ratio saturator.
`timescale 1ns / 1ps

package tvrs_pkg;

    localparam int FIELD_JOINTS        = 3;
    localparam int TORQUE_W            = 32;
    localparam int LIMIT_W             = 31;
    localparam int RATIO_W             = 16;
    localparam int CFG_INDEX_W         = 2;
    localparam int JOINT_COUNT_DEFAULT = 3;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 31'd2949120;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_LIMIT_A = 2'd0,
        REG_LIMIT_B = 2'd1,
        REG_LIMIT_C = 2'd2
    } reg_index_t;

    typedef logic [TORQUE_W-1:0] mag_t;
    typedef logic [LIMIT_W-1:0]  limit_t;
    typedef limit_t [FIELD_JOINTS-1:0] limits_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] torque_in_a;
        logic signed [TORQUE_W-1:0] torque_in_b;
        logic signed [TORQUE_W-1:0] torque_in_c;
    } in_beat_t;

    typedef struct packed {
        logic signed [TORQUE_W-1:0] torque_out_a;
        logic signed [TORQUE_W-1:0] torque_out_b;
        logic signed [TORQUE_W-1:0] torque_out_c;
        logic                       was_scaled;
        logic [1:0]                 limiting_joint;
    } out_beat_t;

    // Classified vector handed from the front to the back through the queue.
    typedef struct packed {
        mag_t [FIELD_JOINTS-1:0] mag;
        logic [FIELD_JOINTS-1:0] neg;
        logic [1:0]              best;
        logic                    found;
        limit_t                  lim_best;
    } cls_t;

endpackage

### sv/tvrs_front.sv
// Front end: takes torque beats, forms magnitudes and picks the limiting joint.
`timescale 1ns / 1ps

module tvrs_front #(
    parameter int JOINT_COUNT = tvrs_pkg::JOINT_COUNT_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  tvrs_pkg::in_beat_t in_data,
    input  tvrs_pkg::limits_t limits,
    input  logic              q_full,
    output logic              q_push,
    output tvrs_pkg::cls_t    q_data
);
    import tvrs_pkg::*;

    typedef struct packed {
        mag_t [FIELD_JOINTS-1:0] mag;
        logic [FIELD_JOINTS-1:0] neg;
        logic [FIELD_JOINTS-1:0] cand;
    } mag_stage_t;

    logic       v1_reg, v2_reg, v3_reg, v4_reg;
    mag_stage_t s1_reg, s1_next;
    mag_stage_t s2_reg, s3_reg, s4_reg;
    logic [62:0] pl2_reg, pr2_reg, pl4_reg, pr4_reg;
    logic [1:0]  best3_reg, best3_next;
    logic        found3_reg, found3_next;
    mag_t        bmag3_reg, bmag3_next;
    limit_t      blim3_reg, blim3_next;
    logic [1:0]  best4_reg;
    logic        found4_reg;
    limit_t      blim4_reg;
    logic        adv;
    logic        take_last;
    mag_t [FIELD_JOINTS-1:0] raw;

    assign adv      = !(v4_reg && q_full);
    assign in_stall = !adv;
    assign q_push   = v4_reg && adv;

    assign raw[0] = in_data.torque_in_a;
    assign raw[1] = in_data.torque_in_b;
    assign raw[2] = in_data.torque_in_c;

    // Two's complement negation also gives the right magnitude for -2^31.
    always_comb
    begin
        for (int j = 0; j < FIELD_JOINTS; j++)
        begin
            s1_next.neg[j]  = raw[j][TORQUE_W-1];
            s1_next.mag[j]  = raw[j][TORQUE_W-1] ? (~raw[j] + 32'd1) : raw[j];
            s1_next.cand[j] = (j < JOINT_COUNT) && (raw[j] != '0);
        end
    end

    // Joint 1 replaces joint 0 when joint 0 is no candidate or on a strictly smaller ratio.
    always_comb
    begin
        if (s2_reg.cand[1] && (!s2_reg.cand[0] || (pl2_reg < pr2_reg)))
        begin
            best3_next = 2'd1;
            bmag3_next = s2_reg.mag[1];
            blim3_next = limits[1];
        end
        else
        begin
            best3_next = 2'd0;
            bmag3_next = s2_reg.mag[0];
            blim3_next = limits[0];
        end
        found3_next = s2_reg.cand[0] || s2_reg.cand[1];
    end

    assign take_last = s4_reg.cand[2] && (!found4_reg || (pl4_reg < pr4_reg));

    always_comb
    begin
        q_data.mag      = s4_reg.mag;
        q_data.neg      = s4_reg.neg;
        q_data.found    = found4_reg || s4_reg.cand[2];
        q_data.best     = take_last ? 2'd2 : best4_reg;
        q_data.lim_best = take_last ? limits[2] : blim4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg     <= s1_next;
            s2_reg     <= s1_reg;
            pl2_reg    <= 63'(limits[1] * s1_reg.mag[0]);
            pr2_reg    <= 63'(limits[0] * s1_reg.mag[1]);
            s3_reg     <= s2_reg;
            best3_reg  <= best3_next;
            found3_reg <= found3_next;
            bmag3_reg  <= bmag3_next;
            blim3_reg  <= blim3_next;
            s4_reg     <= s3_reg;
            best4_reg  <= best3_reg;
            found4_reg <= found3_reg;
            blim4_reg  <= blim3_reg;
            pl4_reg    <= 63'(limits[2] * bmag3_reg);
            pr4_reg    <= 63'(blim3_reg * s3_reg.mag[2]);
        end
    end

    // The front only holds back input when its last stage cannot unload.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (v4_reg && q_full))
        else $error("front stalled without a blocked last stage");

endmodule

### sv/tvrs_queue.sv
// Short FIFO that decouples the classifying front from the scaling back.
`timescale 1ns / 1ps

module tvrs_queue #(
    parameter int DEPTH = tvrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  tvrs_pkg::cls_t push_data,
    output logic           full,
    input  logic           pop,
    output logic           not_empty,
    output tvrs_pkg::cls_t pop_data
);
    import tvrs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_pop    = pop && not_empty;
    assign pop_data  = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count beyond depth");

endmodule

### sv/tvrs_back.sv
// Back end: divides out the scale ratio, scales the torques and holds the result.
`timescale 1ns / 1ps

module tvrs_back #(
    parameter int JOINT_COUNT = tvrs_pkg::JOINT_COUNT_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_not_empty,
    input  tvrs_pkg::cls_t     q_data,
    output logic               q_pop,
    output logic               out_valid,
    input  logic               out_stall,
    output tvrs_pkg::out_beat_t out_data
);
    import tvrs_pkg::*;

    localparam int STEPS = RATIO_W;

    typedef struct packed {
        mag_t [FIELD_JOINTS-1:0] mag;
        logic [FIELD_JOINTS-1:0] neg;
        logic [1:0]              joint;
        logic                    scale;
        mag_t                    rem;
        mag_t                    div;
        logic [RATIO_W-1:0]      quo;
    } div_stage_t;

    logic       adv;
    logic       dv_reg [STEPS+1];
    div_stage_t ds_reg [STEPS+1];
    div_stage_t ds_next [STEPS];
    div_stage_t d0_next;
    logic       mv_reg;
    div_stage_t ms_reg;
    logic [47:0] prod_reg [FIELD_JOINTS];
    logic       out_valid_reg;
    out_beat_t  out_reg, out_next;
    mag_t [FIELD_JOINTS-1:0] res;

    assign adv       = !(out_valid_reg && out_stall);
    assign q_pop     = adv;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // When scaling the limit is below the magnitude, so the remainder starts as the limit.
    always_comb
    begin
        d0_next.mag   = q_data.mag;
        d0_next.neg   = q_data.neg;
        d0_next.joint = q_data.found ? q_data.best : 2'd0;
        d0_next.scale = q_data.found && ({1'b0, q_data.lim_best} < q_data.mag[q_data.best]);
        d0_next.rem   = {1'b0, q_data.lim_best};
        d0_next.div   = q_data.mag[q_data.best];
        d0_next.quo   = '0;
    end

    // One restoring division step per stage; the shifted-in dividend bits are zero.
    always_comb
    begin
        logic [TORQUE_W:0] sh;
        logic              ge;
        for (int k = 0; k < STEPS; k++)
        begin
            sh = {ds_reg[k].rem, 1'b0};
            ge = (sh >= {1'b0, ds_reg[k].div});
            ds_next[k]     = ds_reg[k];
            ds_next[k].rem = ge ? TORQUE_W'(sh - {1'b0, ds_reg[k].div}) : TORQUE_W'(sh);
            ds_next[k].quo = {ds_reg[k].quo[RATIO_W-2:0], ge};
        end
    end

    always_comb
    begin
        mag_t m;
        for (int j = 0; j < FIELD_JOINTS; j++)
        begin
            m      = ms_reg.scale ? prod_reg[j][47:16] : ms_reg.mag[j];
            res[j] = (j < JOINT_COUNT) ? (ms_reg.neg[j] ? (~m + 32'd1) : m) : '0;
        end
        out_next.torque_out_a   = res[0];
        out_next.torque_out_b   = res[1];
        out_next.torque_out_c   = res[2];
        out_next.was_scaled     = ms_reg.scale;
        out_next.limiting_joint = ms_reg.joint;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= STEPS; k++)
            begin
                dv_reg[k] <= 1'b0;
            end
            mv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            dv_reg[0] <= q_not_empty;
            for (int k = 0; k < STEPS; k++)
            begin
                dv_reg[k+1] <= dv_reg[k];
            end
            mv_reg        <= dv_reg[STEPS];
            out_valid_reg <= mv_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ds_reg[0] <= d0_next;
            for (int k = 0; k < STEPS; k++)
            begin
                ds_reg[k+1] <= ds_next[k];
            end
            ms_reg <= ds_reg[STEPS];
            for (int j = 0; j < FIELD_JOINTS; j++)
            begin
                prod_reg[j] <= 48'(ds_reg[STEPS].mag[j] * ds_reg[STEPS].quo);
            end
            out_reg <= out_next;
        end
    end

    a_joint_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.limiting_joint != 2'd3))
        else $error("limiting joint outside the field joints");

endmodule

### sv/torque_vector_ratio_saturator_core.sv
// Top level of the torque vector ratio saturator: limit registers, front, queue and back.
`timescale 1ns / 1ps

// Channel   Handshake             Payload        Beat
// input     in_valid / in_stall   in_data        one torque vector
// output    out_valid / out_stall out_data       one saturated vector and flags
// config    cfg_we                cfg_index/data one limit register write
//
// A new vector is taken every cycle unless the input stalls; the path runs through
// the four selection stages, the queue, and the sixteen stage divider.
// Reset clears all valid flags and the queue and loads each limit with 45.0.
// An output stall holds the back, the queue fills, and only then the input stalls.
module torque_vector_ratio_saturator_core #(
    parameter int JOINT_COUNT = tvrs_pkg::JOINT_COUNT_DEFAULT,
    parameter int QUEUE_DEPTH = tvrs_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  tvrs_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_stall,
    output tvrs_pkg::out_beat_t                 out_data,
    input  logic                                cfg_we,
    input  logic [tvrs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [tvrs_pkg::LIMIT_W-1:0]        cfg_data
);
    import tvrs_pkg::*;

    limits_t limit_reg;
    logic    q_full, q_push, q_pop, q_not_empty;
    cls_t    q_in, q_out;

    // Writes to an index past the last limit register fall through and are dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < FIELD_JOINTS; j++)
            begin
                limit_reg[j] <= LIMIT_RESET;
            end
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_LIMIT_A: limit_reg[0] <= cfg_data;
                REG_LIMIT_B: limit_reg[1] <= cfg_data;
                REG_LIMIT_C: limit_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    tvrs_front #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .limits   (limit_reg),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    tvrs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_out)
    );

    tvrs_back #(
        .JOINT_COUNT (JOINT_COUNT)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_data      (q_out),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data)
    );

endmodule

### test/tb_top.sv
// Testbench of the torque vector ratio saturator: random and directed vectors against a predictor.
`timescale 1ns / 1ps

module tb_top;
    import tvrs_pkg::*;

    // Clock, reset and the block's ports.
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_beat_t in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_beat_t out_data;
    logic cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0] cfg_data = '0;

    // Output idling is switched off towards the end of the run.
    bit out_idle_on = 1'b1;

    always #10 clk = ~clk;

    torque_vector_ratio_saturator_core i_dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // The scoreboard keeps its own copy of the limit registers and a queue of
    // saturated vectors that the block still owes.
    class saturation_board;
        limit_t joint_limit[FIELD_JOINTS];
        out_beat_t owed_vectors[$];
        int mismatch_count;

        function void reset_limits();
            for (int j = 0; j < FIELD_JOINTS; j++)
                joint_limit[j] = LIMIT_RESET;
        endfunction

        function void write_limit(int idx, logic [LIMIT_W-1:0] val);
            if (idx < FIELD_JOINTS)
                joint_limit[idx] = val;
        endfunction

        // Works out the saturated vector for one accepted torque vector.
        function void note_vector(in_beat_t v);
            logic [31:0] raw[FIELD_JOINTS];
            logic [63:0] mag[FIELD_JOINTS];
            logic [63:0] ratio;
            logic [63:0] m;
            logic [31:0] res[FIELD_JOINTS];
            bit found;
            bit scale;
            int best;
            out_beat_t o;
            raw[0] = v.torque_in_a;
            raw[1] = v.torque_in_b;
            raw[2] = v.torque_in_c;
            found = 1'b0;
            best = 0;
            scale = 1'b0;
            ratio = '0;
            for (int j = 0; j < FIELD_JOINTS; j++)
                mag[j] = raw[j][31] ? {32'd0, (~raw[j]) + 32'd1} : {32'd0, raw[j]};
            for (int j = 0; j < FIELD_JOINTS; j++) begin
                if (mag[j] == 0)
                    continue;
                if (!found) begin
                    found = 1'b1;
                    best = j;
                end
                else if (64'(joint_limit[j]) * mag[best] < 64'(joint_limit[best]) * mag[j])
                    best = j;
            end
            if (found && 64'(joint_limit[best]) < mag[best]) begin
                scale = 1'b1;
                ratio = (64'(joint_limit[best]) << 16) / mag[best];
            end
            for (int j = 0; j < FIELD_JOINTS; j++) begin
                m = scale ? ((mag[j] * ratio) >> 16) : mag[j];
                res[j] = raw[j][31] ? (32'd0 - m[31:0]) : m[31:0];
            end
            o.torque_out_a = res[0];
            o.torque_out_b = res[1];
            o.torque_out_c = res[2];
            o.was_scaled = scale;
            o.limiting_joint = found ? 2'(best) : 2'd0;
            owed_vectors.push_back(o);
        endfunction

        function void check_result(out_beat_t got);
            out_beat_t exp_v;
            if (owed_vectors.size() == 0) begin
                report("unexpected beat", '0, got);
                return;
            end
            exp_v = owed_vectors.pop_front();
            if (got.torque_out_a !== exp_v.torque_out_a) report("torque_out_a", exp_v, got);
            if (got.torque_out_b !== exp_v.torque_out_b) report("torque_out_b", exp_v, got);
            if (got.torque_out_c !== exp_v.torque_out_c) report("torque_out_c", exp_v, got);
            if (got.was_scaled !== exp_v.was_scaled) report("was_scaled", exp_v, got);
            if (got.limiting_joint !== exp_v.limiting_joint)
                report("limiting_joint", exp_v, got);
        endfunction

        function void report(string what, out_beat_t e, out_beat_t g);
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("MISMATCH %s: expected %h actual %h", what, e, g);
        endfunction
    endclass

    saturation_board board = new();

    // Results are taken at the rising edge, and the output stall is replanned
    // at the falling edge in random bursts.
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            board.check_result(out_data);

    initial begin
        int burst;
        forever begin
            @(negedge clk);
            if (out_idle_on && $urandom_range(0, 3) == 0) begin
                burst = $urandom_range(1, 15);
                out_stall <= 1'b1;
                repeat (burst) @(negedge clk);
            end
            out_stall <= 1'b0;
        end
    end

    // Presents one beat and holds it until the block accepts it. Valid stays
    // high afterwards so that the next beat can follow without a gap.
    task automatic send_vector(in_beat_t v, bit allow_gaps);
        if (allow_gaps && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_data <= v;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        board.note_vector(v);
        @(negedge clk);
    endtask

    task automatic write_limit(reg_index_t idx, logic [LIMIT_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_we <= 1'b1;
        @(negedge clk);
        cfg_we <= 1'b0;
        board.write_limit(int'(idx), val);
        @(negedge clk);
    endtask

    // Waits until every owed vector has come back, plus a latency margin.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.owed_vectors.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Torque values biased towards the edges and towards the limit range.
    function automatic logic [31:0] pick_torque();
        case ($urandom_range(0, 7))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return 32'($urandom_range(0, 200)) - 32'd100;
            4, 5: return {{12{$urandom_range(0, 1) == 1}}, 20'($urandom)} ^ 32'($urandom_range(0, 1));
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [LIMIT_W-1:0] pick_limit();
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return LIMIT_RESET;
            3: return 31'($urandom_range(0, 1 << 22));
            default: return 31'($urandom);
        endcase
    endfunction

    function automatic in_beat_t make_vector(logic [31:0] a, logic [31:0] b, logic [31:0] c);
        in_beat_t v;
        v.torque_in_a = a;
        v.torque_in_b = b;
        v.torque_in_c = c;
        return v;
    endfunction

    initial begin
        board.reset_limits();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed beats at the reset limits of 45.0.
        send_vector(make_vector(32'd0, 32'd0, 32'd0), 0);
        send_vector(make_vector(32'h8000_0000, 32'h7FFF_FFFF, 32'd1), 0);
        send_vector(make_vector(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF), 0);
        send_vector(make_vector(32'd2949120, 32'd2949120, 32'd0), 0);
        send_vector(make_vector(32'd2949121, -32'sd2949121, 32'd5), 0);
        send_vector(make_vector(32'd0, 32'h0100_0000, -32'sd100000000), 0);
        send_vector(make_vector(32'd0, 32'd0, 32'h8000_0000), 0);
        send_vector(make_vector(-32'sd65536, 32'd65536, 32'h0FFF_FFFF), 0);
        drain();

        // Zero limit on one joint and the largest limit on another.
        write_limit(REG_LIMIT_A, '0);
        write_limit(REG_LIMIT_B, '1);
        write_limit(REG_LIMIT_C, 31'd65536);
        send_vector(make_vector(32'd1, 32'h8000_0000, 32'd65537), 0);
        send_vector(make_vector(32'd0, 32'h8000_0000, 32'd65536), 0);
        send_vector(make_vector(32'd0, 32'h7FFF_FFFF, -32'sd131072), 0);
        send_vector(make_vector(-32'sd1, 32'd0, 32'd0), 0);
        send_vector(make_vector(32'd0, 32'd0, 32'hFFFF_FFFF), 0);
        drain();

        // Equal limits give ties between equal magnitudes.
        write_limit(REG_LIMIT_A, 31'd65536);
        write_limit(REG_LIMIT_B, 31'd65536);
        write_limit(REG_LIMIT_C, 31'd65536);
        send_vector(make_vector(32'd200000, -32'sd200000, 32'd200000), 0);
        send_vector(make_vector(32'd100, 32'h8000_0000, 32'h8000_0000), 0);
        drain();

        // Random phases, each under fresh limits; the last one runs without idling.
        for (int phase = 0; phase < 11; phase++) begin
            write_limit(REG_LIMIT_A, pick_limit());
            write_limit(REG_LIMIT_B, pick_limit());
            write_limit(REG_LIMIT_C, pick_limit());
            if (phase == 10)
                out_idle_on = 1'b0;
            for (int n = 0; n < 150; n++)
                send_vector(make_vector(pick_torque(), pick_torque(), pick_torque()),
                            phase != 10);
            drain();
        end

        if (board.mismatch_count == 0 && board.owed_vectors.size() == 0)
        begin
            $display("tb_top passed");
        end
        else
        begin
            $display("tb_top failed");
        end
        $finish;
    end

    // Guard against a hung handshake.
    initial begin
        #5ms;
        $display("tb_top failed");
        $finish;
    end

endmodule
